// ===== src/metr_pkg.sv =====
// Shared types and constants for the Manchester edge-timing receiver.
// No dependencies; imported by every module under src.
package metr_pkg;

	localparam int NUM_PORTS  = 4;
	localparam int PORT_W     = 2;
	localparam int TS_W       = 32;
	localparam int BT_W       = 20;
	localparam int LIM_W      = BT_W + 3;
	localparam int D5_W       = TS_W + 3;
	localparam int POS_W      = 9;
	localparam int BIT_CNT_W  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [BT_W-1:0] BIT_TIME_RESET = BT_W'(5000);

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_END_GOOD = 2'd1,
		KIND_END_BAD  = 2'd2,
		KIND_RESYNC   = 2'd3
	} metr_kind_t;

	// interval windows, open on both sides: 4T < 5d < 6T full, 2T < 5d < 3T half
	typedef struct packed {
		logic [LIM_W-1:0] full_lo;
		logic [LIM_W-1:0] full_hi;
		logic [LIM_W-1:0] half_lo;
		logic [LIM_W-1:0] half_hi;
	} metr_lim_t;

	// classified edge handed from the front to the back
	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic              level;
		logic              full;
		logic              half;
	} metr_edge_t;

	function automatic metr_lim_t metr_limits(input logic [BT_W-1:0] t);
		metr_lim_t l;
		l.full_lo = {t, 2'b00, 1'b0} >> 1;
		l.full_hi = LIM_W'({t, 2'b00}) + LIM_W'({t, 1'b0});
		l.half_lo = LIM_W'({t, 1'b0});
		l.half_hi = LIM_W'({t, 1'b0}) + LIM_W'(t);
		return l;
	endfunction

endpackage

// ===== src/metr_front.sv =====
// Front end: accepts edges, keeps per-port last edge times and the timing
// windows, and classifies each interval. Depends on metr_pkg.
module metr_front import metr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [BT_W-1:0]     cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [PORT_W-1:0]   port,
	input  logic                level,
	input  logic [TS_W-1:0]     timestamp,
	output logic                push,
	output metr_edge_t          push_data,
	input  logic                fifo_full
);

	metr_lim_t         lim_q;
	logic [TS_W-1:0]   last_q [NUM_PORTS];
	logic              valid_s1;
	logic [PORT_W-1:0] port_s1;
	logic              level_s1;
	logic [TS_W-1:0]   d_s1;
	logic [D5_W-1:0]   d5;
	logic              port_ok;
	logic              accept;

	assign port_ok  = 32'(port) < NUM_PORTS;
	assign in_stall = valid_s1 && fifo_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q    <= metr_limits(BIT_TIME_RESET);
			valid_s1 <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				last_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				lim_q <= metr_limits(cfg_wr_data);
			end
			if (!in_stall) begin
				valid_s1 <= accept && port_ok;
			end
			if (accept && port_ok) begin
				last_q[port] <= timestamp;
			end
		end
	end

	// payload: interval modulo 2^32
	always_ff @(posedge clk) begin
		if (accept) begin
			port_s1  <= port;
			level_s1 <= level;
			d_s1     <= timestamp - last_q[port];
		end
	end

	assign d5 = D5_W'({d_s1, 2'b00}) + D5_W'(d_s1);

	always_comb begin
		push_data.port  = port_s1;
		push_data.level = level_s1;
		push_data.full  = (d5 > D5_W'(lim_q.full_lo)) && (d5 < D5_W'(lim_q.full_hi));
		push_data.half  = (d5 > D5_W'(lim_q.half_lo)) && (d5 < D5_W'(lim_q.half_hi));
	end

endmodule

// ===== src/metr_fifo.sv =====
// Short queue of classified edges between front and back.
// Depends on metr_pkg.
module metr_fifo import metr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  metr_edge_t push_data,
	input  logic       pop,
	output metr_edge_t pop_data,
	output logic       full,
	output logic       empty
);

	metr_edge_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full     = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/metr_back.sv =====
// Back end: per-port sync, bit and frame assembly, checksum, and the output
// register that drives the result channel. Depends on metr_pkg.
module metr_back import metr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  metr_edge_t        pop_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] out_port,
	output logic [1:0]        kind,
	output logic [7:0]        byte_value,
	output logic [POS_W-1:0]  byte_index
);

	logic                 synced_q    [NUM_PORTS];
	logic                 half_q      [NUM_PORTS];
	logic [BIT_CNT_W-1:0] cnt_q       [NUM_PORTS];
	logic [7:0]           shift_q     [NUM_PORTS];
	logic [POS_W-1:0]     pos_q       [NUM_PORTS];
	logic [7:0]           len_q       [NUM_PORTS];
	logic [7:0]           sum_q       [NUM_PORTS];

	logic                 out_valid_q;
	logic [PORT_W-1:0]    out_port_q;
	metr_kind_t           kind_q;
	logic [7:0]           byte_q;
	logic [POS_W-1:0]     index_q;

	logic                 n_synced, n_half, n_clear, n_res;
	logic [BIT_CNT_W-1:0] n_cnt;
	logic [7:0]           n_shift, n_len, n_sum, b;
	logic [POS_W-1:0]     n_pos, pos;
	metr_kind_t           n_kind;
	logic                 store;
	logic [PORT_W-1:0]    p;

	assign pop = !empty && (!out_valid_q || !out_stall);
	assign p   = pop_data.port;
	assign pos = pos_q[p];
	assign b   = {shift_q[p][6:0], pop_data.level};

	always_comb begin
		n_synced = synced_q[p];
		n_half   = half_q[p];
		n_cnt    = cnt_q[p];
		n_shift  = shift_q[p];
		n_pos    = pos;
		n_len    = len_q[p];
		n_sum    = sum_q[p];
		n_clear  = 1'b0;
		n_res    = 1'b0;
		n_kind   = KIND_BYTE;
		store    = 1'b0;

		if (!synced_q[p]) begin
			if (pop_data.full && pop_data.level) begin
				n_synced = 1'b1;
			end
		end else if (pop_data.full) begin
			store = 1'b1;
		end else if (pop_data.half) begin
			n_half = !half_q[p];
			store  = half_q[p];
		end else begin
			n_res   = 1'b1;
			n_kind  = KIND_RESYNC;
			n_clear = 1'b1;
		end

		if (store) begin
			n_shift = b;
			n_cnt   = cnt_q[p] + 1'b1;
			if (&cnt_q[p]) begin
				n_res   = 1'b1;
				n_shift = '0;
				if (pos == '0) begin
					n_len = b;
				end
				if (pos != '0 && pos == POS_W'(len_q[p]) + 1'b1) begin
					n_kind  = (b == sum_q[p]) ? KIND_END_GOOD : KIND_END_BAD;
					n_clear = 1'b1;
				end else begin
					if (pos != '0) begin
						n_sum = sum_q[p] + b;
					end
					n_pos = pos + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				synced_q[i] <= 1'b0;
				half_q[i]   <= 1'b0;
				cnt_q[i]    <= '0;
				shift_q[i]  <= '0;
				pos_q[i]    <= '0;
				len_q[i]    <= '0;
				sum_q[i]    <= '0;
			end
		end else begin
			if (pop) begin
				out_valid_q <= n_res;
				if (n_clear) begin
					synced_q[p] <= 1'b0;
					half_q[p]   <= 1'b0;
					cnt_q[p]    <= '0;
					shift_q[p]  <= '0;
					pos_q[p]    <= '0;
					len_q[p]    <= '0;
					sum_q[p]    <= '0;
				end else begin
					synced_q[p] <= n_synced;
					half_q[p]   <= n_half;
					cnt_q[p]    <= n_cnt;
					shift_q[p]  <= n_shift;
					pos_q[p]    <= n_pos;
					len_q[p]    <= n_len;
					sum_q[p]    <= n_sum;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload of the result word; a resync reports a zero byte
	always_ff @(posedge clk) begin
		if (pop && n_res) begin
			out_port_q <= p;
			kind_q     <= n_kind;
			byte_q     <= (n_kind == KIND_RESYNC) ? 8'h00 : b;
			index_q    <= pos;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_port   = out_port_q;
	assign kind       = kind_q;
	assign byte_value = byte_q;
	assign byte_index = index_q;

endmodule

// ===== src/manchester_edge_timing_receiver.sv =====
// Four-port Manchester edge-timing receiver, top level.
// With no stall the result word passes the interval register, the queue and the
// output register in that order. Throughput: one edge per cycle while neither
// in_stall nor out_stall holds it, set by the per-port update in the back end.
// Reset (arst_n low): all ports unsynced and cleared, last edge times zero,
// bit time 5000 ticks; the queue and the output register empty.
module manchester_edge_timing_receiver import metr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BT_W-1:0]   cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PORT_W-1:0] port,
	input  logic              level,
	input  logic [TS_W-1:0]   timestamp,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] out_port,
	output logic [1:0]        kind,
	output logic [7:0]        byte_value,
	output logic [POS_W-1:0]  byte_index
);

	logic       push, pop, fifo_full, fifo_empty;
	metr_edge_t push_data, pop_data;

	metr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.port       (port),
		.level      (level),
		.timestamp  (timestamp),
		.push       (push),
		.push_data  (push_data),
		.fifo_full  (fifo_full)
	);

	metr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	metr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (fifo_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_port  (out_port),
		.kind      (kind),
		.byte_value(byte_value),
		.byte_index(byte_index)
	);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the four-port Manchester edge-timing receiver.
// Short stimulus table, then framed and noisy edge streams checked by a line decoder model.
// Depends on src/metr_pkg.sv and src/manchester_edge_timing_receiver.sv.
module tb_top import metr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		metr_kind_t        kind;
		logic [7:0]        value;
		logic [POS_W-1:0]  index;
	} rx_word_t;

	typedef struct {
		logic            synced;
		logic            half_seen;
		logic [TS_W-1:0] last;
		logic [3:0]      nbits;
		logic [7:0]      shift;
		logic [8:0]      pos;
		logic [7:0]      flen;
		logic [7:0]      sum;
	} line_state_t;

	typedef struct {
		logic [PORT_W-1:0] p;
		logic              lvl;
		logic [TS_W-1:0]   ts;
		bit                typed;
		bit                has_word;
		rx_word_t          word;
	} probe_row_t;

	typedef struct {
		logic            lvl;
		logic [TS_W-1:0] gap;
	} line_step_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [BT_W-1:0]   cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [PORT_W-1:0] port = '0;
	logic              level = 1'b0;
	logic [TS_W-1:0]   timestamp = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PORT_W-1:0] out_port;
	logic [1:0]        kind;
	logic [7:0]        byte_value;
	logic [POS_W-1:0]  byte_index;

	manchester_edge_timing_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.port(port), .level(level), .timestamp(timestamp),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_port(out_port), .kind(kind), .byte_value(byte_value), .byte_index(byte_index)
	);

	line_state_t lines[NUM_PORTS];
	logic [BT_W-1:0] bit_time_q;
	longint win_fmin, win_fmax, win_hmin, win_hmax;
	rx_word_t pending_words[$];
	probe_row_t probe_rows[$];
	line_step_t plan_q[NUM_PORTS][$];

	int unsigned mismatches = 0;
	int unsigned edges_sent = 0;
	int unsigned words_seen = 0;
	int unsigned kind_seen[4] = '{0, 0, 0, 0};
	int unsigned held_input_cycles = 0;
	int unsigned burst_left = 0;
	bit want_long = 0;
	bit long_active = 0;
	int long_port = 0;
	bit hold_req = 0;
	int unsigned hold_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_mode_left = 0;
	logic [7:0] pattern_cnt = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[manchester_edge_timing_receiver] ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// 4T < 5d < 6T is a full bit, 2T < 5d < 3T a half bit
	function automatic void classify(input logic [TS_W-1:0] d, input logic [BT_W-1:0] t,
			output bit full, output bit half);
		longint unsigned d5, tt;
		d5 = longint'(d) * 5;
		tt = longint'(t);
		full = (d5 > 4 * tt) && (d5 < 6 * tt);
		half = (d5 > 2 * tt) && (d5 < 3 * tt);
	endfunction

	function automatic void clear_line(input int p);
		logic [TS_W-1:0] keep;
		keep = lines[p].last;
		lines[p] = '{default: '0};
		lines[p].last = keep;
	endfunction

	// advance one port's decoder by one edge; returns 1 when a word comes out
	function automatic bit decode_edge(input logic [PORT_W-1:0] p, input logic lvl,
			input logic [TS_W-1:0] ts, output rx_word_t w);
		bit full, half, store, got;
		logic [7:0] b;
		logic [8:0] pos;
		store = 0;
		got = 0;
		w = '0;
		classify(ts - lines[p].last, bit_time_q, full, half);
		if (!lines[p].synced) begin
			if (full && lvl)
				lines[p].synced = 1'b1;
		end else if (full) begin
			store = 1;
		end else if (half) begin
			if (!lines[p].half_seen) begin
				lines[p].half_seen = 1'b1;
			end else begin
				lines[p].half_seen = 1'b0;
				store = 1;
			end
		end else begin
			w.port = p;
			w.kind = KIND_RESYNC;
			w.value = 8'd0;
			w.index = lines[p].pos;
			clear_line(p);
			got = 1;
		end
		if (store) begin
			lines[p].shift = {lines[p].shift[6:0], lvl};
			lines[p].nbits = lines[p].nbits + 4'd1;
			if (lines[p].nbits == 4'd8) begin
				b = lines[p].shift;
				pos = lines[p].pos;
				lines[p].nbits = '0;
				lines[p].shift = '0;
				if (pos == 9'd0)
					lines[p].flen = b;
				w.port = p;
				w.value = b;
				w.index = pos;
				if (pos != 9'd0 && pos == 9'(lines[p].flen) + 9'd1) begin
					w.kind = (b == lines[p].sum) ? KIND_END_GOOD : KIND_END_BAD;
					clear_line(p);
				end else begin
					if (pos != 9'd0)
						lines[p].sum = lines[p].sum + b;
					w.kind = KIND_BYTE;
					lines[p].pos = pos + 9'd1;
				end
				got = 1;
			end
		end
		lines[p].last = ts;
		return got;
	endfunction

	// offer one edge, wait for it to be taken, then predict
	task automatic deliver(input logic [PORT_W-1:0] p, input logic lvl, input logic [TS_W-1:0] ts,
			input bit typed, input bit has_word, input rx_word_t typed_word);
		int unsigned gap;
		rx_word_t w;
		bit got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		port <= p;
		level <= lvl;
		timestamp <= ts;
		do @(posedge clk); while (in_stall);
		edges_sent++;
		got = decode_edge(p, lvl, ts, w);
		if (typed) begin
			if (has_word)
				pending_words.push_back(typed_word);
		end else if (got) begin
			pending_words.push_back(w);
		end
	endtask

	task automatic add_row(input logic [PORT_W-1:0] p, input logic lvl, input logic [TS_W-1:0] ts,
			input bit typed, input bit has_word, input metr_kind_t k,
			input logic [7:0] v, input logic [8:0] idx);
		probe_row_t r;
		r.p = p;
		r.lvl = lvl;
		r.ts = ts;
		r.typed = typed;
		r.has_word = has_word;
		r.word = '{port: p, kind: k, value: v, index: idx};
		probe_rows.push_back(r);
	endtask

	task automatic write_bit_time(input logic [BT_W-1:0] v);
		longint t;
		while (pending_words.size() != 0) @(posedge clk);
		// an edge that ends no word may still be in flight
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bit_time_q = v;
		t = longint'(v);
		win_fmin = (4 * t) / 5 + 1;
		win_fmax = (6 * t - 1) / 5;
		win_hmin = (2 * t) / 5 + 1;
		win_hmax = (3 * t - 1) / 5;
	endtask

	function automatic logic [TS_W-1:0] full_gap();
		return TS_W'(win_fmin) + $urandom_range(0, 32'(win_fmax - win_fmin));
	endfunction

	function automatic logic [TS_W-1:0] half_gap();
		return TS_W'(win_hmin) + $urandom_range(0, 32'(win_hmax - win_hmin));
	endfunction

	// intervals on and around the window edges, plus wild ones
	function automatic logic [TS_W-1:0] noise_gap();
		longint v;
		case ($urandom_range(0, 11))
			0: v = win_fmin - 1;
			1: v = win_fmin;
			2: v = win_fmax;
			3: v = win_fmax + 1;
			4: v = win_hmin - 1;
			5: v = win_hmin;
			6: v = win_hmax;
			7: v = win_hmax + 1;
			8, 9: v = longint'($urandom);
			default: v = longint'($urandom_range(0, 3));
		endcase
		if (v < 0)
			v = 0;
		return TS_W'(v);
	endfunction

	function automatic void push_byte(input int p, input logic [7:0] b, input bit long_frame);
		for (int i = 7; i >= 0; i--) begin
			if (!long_frame && $urandom_range(0, 99) == 0)
				plan_q[p].push_back('{lvl: 1'($urandom), gap: noise_gap()});
			if (!long_frame && win_hmin <= win_hmax && $urandom_range(0, 2) == 0) begin
				plan_q[p].push_back('{lvl: ~b[i], gap: half_gap()});
				plan_q[p].push_back('{lvl: b[i], gap: half_gap()});
			end else begin
				plan_q[p].push_back('{lvl: b[i], gap: full_gap()});
			end
		end
	endfunction

	function automatic void make_plan(input int p);
		int unsigned len, n;
		logic [7:0] sum, data;
		logic [TS_W-1:0] d;
		bit full, half, long_frame;
		if (!want_long && (win_fmin > win_fmax || $urandom_range(0, 9) < 3)) begin
			n = $urandom_range(1, 10);
			repeat (n) plan_q[p].push_back('{lvl: 1'($urandom), gap: noise_gap()});
			return;
		end
		long_frame = want_long;
		if (want_long) begin
			len = 60;
			want_long = 0;
			long_active = 1;
			long_port = p;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(0, 3);
				6, 7, 8: len = $urandom_range(4, 12);
				default: len = $urandom_range(13, 40);
			endcase
		end
		// drop whatever the port was doing, then lock on a full interval at level 1
		do begin
			d = $urandom;
			classify(d, bit_time_q, full, half);
		end while (full || half);
		plan_q[p].push_back('{lvl: 1'($urandom), gap: d});
		plan_q[p].push_back('{lvl: 1'b1, gap: full_gap()});
		sum = '0;
		push_byte(p, 8'(len), long_frame);
		repeat (len) begin
			data = 8'($urandom);
			sum = sum + data;
			push_byte(p, data, long_frame);
		end
		if ($urandom_range(0, 3) == 0)
			sum = sum ^ 8'($urandom_range(1, 255));
		push_byte(p, sum, long_frame);
	endfunction

	task automatic run_random(input int unsigned count, input bit with_hold);
		int unsigned n;
		int p;
		line_step_t s;
		n = 0;
		while (n < count || long_active) begin
			if (long_active && $urandom_range(0, 9) != 0)
				p = long_port;
			else
				p = $urandom_range(0, NUM_PORTS - 1);
			if (plan_q[p].size() == 0)
				make_plan(p);
			s = plan_q[p].pop_front();
			deliver(PORT_W'(p), s.lvl, lines[p].last + s.gap, 0, 0, '0);
			if (long_active && p == long_port && plan_q[p].size() == 0)
				long_active = 0;
			n++;
			if (with_hold && n == 30)
				hold_req = 1'b1;
		end
		in_valid <= 1'b0;
	endtask

	// receiver: changing stall patterns, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_mode_left = $urandom_range(32, 200);
		end else begin
			stall_mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			if (in_stall)
				held_input_cycles++;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= pattern_cnt[2];
			endcase
		end
		pattern_cnt <= pattern_cnt + 8'd1;
	end

	always @(posedge clk) begin
		rx_word_t want;
		if (out_valid && !out_stall) begin
			words_seen++;
			kind_seen[kind]++;
			if (pending_words.size() == 0) begin
				flag_mismatch($sformatf("unexpected word port %0d kind %0d value %0d index %0d",
					out_port, kind, byte_value, byte_index));
			end else begin
				want = pending_words.pop_front();
				if (out_port !== want.port)
					flag_mismatch($sformatf("out_port %0d, want %0d", out_port, want.port));
				if (kind !== want.kind)
					flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (byte_value !== want.value)
					flag_mismatch($sformatf("byte_value %0d, want %0d", byte_value, want.value));
				if (byte_index !== want.index)
					flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.index));
			end
		end
	end

	initial begin
		logic [BT_W-1:0] phase_bt[9];
		int unsigned phase_items[9];
		int unsigned waited;
		phase_bt = '{20'd5000, 20'hFFFFF, 20'd1, 20'd0, 20'd2, 20'd3, 20'd37, 20'd0, 20'd160};
		phase_bt[7] = BT_W'($urandom_range(4, 20'hFFFFF));
		phase_items = '{60, 40, 30, 30, 40, 40, 40, 50, 60};
		foreach (lines[q])
			lines[q] = '{default: '0};
		bit_time_q = BIT_TIME_RESET;

		// port 3: stamp extremes, lock across the wrap, both bit shapes, window edges
		add_row(2'd3, 1'b0, 32'd0, 1, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b1, 32'hFFFF_FFFF, 1, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b1, 32'd4999, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b0, 32'd7499, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b1, 32'd9999, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b1, 32'd14000, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b0, 32'd19999, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		add_row(2'd3, 1'b0, 32'd25999, 1, 1, KIND_RESYNC, 8'd0, 9'd0);
		// port 1: empty frame, length byte and checksum both zero
		add_row(2'd1, 1'b1, 32'd5000, 0, 0, KIND_BYTE, 8'd0, 9'd0);
		for (int k = 1; k <= 16; k++) begin
			if (k == 8)
				add_row(2'd1, 1'b0, 32'(5000 + 5000 * k), 1, 1, KIND_BYTE, 8'd0, 9'd0);
			else if (k == 16)
				add_row(2'd1, 1'b0, 32'(5000 + 5000 * k), 1, 1, KIND_END_GOOD, 8'd0, 9'd1);
			else
				add_row(2'd1, 1'b0, 32'(5000 + 5000 * k), 0, 0, KIND_BYTE, 8'd0, 9'd0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i])
			deliver(probe_rows[i].p, probe_rows[i].lvl, probe_rows[i].ts,
				probe_rows[i].typed, probe_rows[i].has_word, probe_rows[i].word);
		in_valid <= 1'b0;

		for (int i = 0; i < 9; i++) begin
			foreach (plan_q[q])
				plan_q[q].delete();
			write_bit_time(phase_bt[i]);
			want_long = (i == 6);
			run_random(phase_items[i], i == 0);
		end

		waited = 0;
		while (pending_words.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_words.size() != 0)
			flag_mismatch($sformatf("%0d expected words never came out", pending_words.size()));

		$display("Ran %0d edges under 9 bit times (0, 1 and 1048575 among them), %0d words out.",
			edges_sent, words_seen);
		$display("Bytes %0d, good ends %0d, bad ends %0d, resyncs %0d; one 60-byte frame; %0d %s",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], held_input_cycles,
			"input stall cycles during the hold-off.");
		if (mismatches == 0)
			$display("[manchester_edge_timing_receiver] OK");
		else
			$display("[manchester_edge_timing_receiver] ERROR");
		$finish;
	end

endmodule
